// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file of the key/hex16 parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define AST_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/kh16_pkg.sv -----
// Package: types, codes and helpers of the key/hex16 field parser.
`timescale 1ns / 1ps
package kh16_pkg;

  // Largest supported key length (default of the top-level parameter)
  localparam int KEY_MAX_CHARS_DEF = 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEY_CHARS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_KEY_LENGTH = 2'd1;
  localparam int CFG_DATA_W = 64;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NAME  = 2'd1;
  localparam logic [1:0] ST_VALUE = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_EQ  = 8'h3D;

  // Digits in a value
  localparam logic [2:0] HEX_DIGITS = 3'd4;

  // Parser phase
  typedef enum logic [2:0] {
    PH_KEY    = 3'd0,
    PH_DIGITS = 3'd1,
    PH_TERM   = 3'd2,
    PH_SKIP   = 3'd3
  } kh16_phase_t;

  // One result item from the parse core to the output stage
  typedef struct packed {
    logic        valid;
    logic [1:0]  status;
    logic [15:0] value;
  } kh16_result_t;

  // Hex digit decode: {is_digit, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- sv/kh16_if.sv -----
// Valid/ready channel interfaces of the key/hex16 field parser.
`timescale 1ns / 1ps

// Text byte channel
interface kh16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

// Result channel
interface kh16_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] value;
  modport source (output valid, output status, output value, input ready);
  modport sink   (input valid, input status, input value, output ready);
endinterface

// Register write channel
interface kh16_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/kh16_cfg_regs.sv -----
// Configuration registers: key characters and clamped key length.
`timescale 1ns / 1ps
module kh16_cfg_regs import kh16_pkg::*; #(
  parameter int KEY_MAX_CHARS = KEY_MAX_CHARS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [CFG_IDX_W-1:0]       wr_idx,
  input  logic [CFG_DATA_W-1:0]      wr_data,
  output logic [KEY_MAX_CHARS*8-1:0] key_chars,
  output logic [3:0]                 key_len
);

  localparam logic [3:0] LEN_MAX = 4'(KEY_MAX_CHARS);

  logic [KEY_MAX_CHARS*8-1:0] key_chars_r;
  logic [3:0]                 key_len_r;

  // Register writes; bytes past the supported key length are never read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_chars_r <= '0;
      key_len_r   <= '0;
    end else if (wr_en) begin
      unique case (wr_idx)
        CFG_IDX_KEY_CHARS:  key_chars_r <= wr_data[KEY_MAX_CHARS*8-1:0];
        CFG_IDX_KEY_LENGTH: key_len_r   <= wr_data[3:0];
        default: ;
      endcase
    end
  end

  // Lengths above the supported maximum act as the maximum
  assign key_chars = key_chars_r;
  assign key_len   = (key_len_r > LEN_MAX) ? LEN_MAX : key_len_r;

endmodule

// ----- sv/kh16_parse_core.sv -----
// Parse state machine: decides each text byte and issues at most one result.
`timescale 1ns / 1ps
module kh16_parse_core import kh16_pkg::*; #(
  parameter int KEY_MAX_CHARS = KEY_MAX_CHARS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [7:0]                 ch,
  input  logic [KEY_MAX_CHARS*8-1:0] key_chars,
  input  logic [3:0]                 key_len,
  output kh16_result_t               res
);

  kh16_phase_t phase_r, phase_nxt;
  logic [3:0]  key_pos_r, key_pos_nxt;
  logic [2:0]  digit_cnt_r, digit_cnt_nxt;
  logic [15:0] accum_r, accum_nxt;

  logic [7:0]  want;
  logic [4:0]  hex;
  logic [2:0]  cnt_inc;
  logic        fin;
  logic [1:0]  fin_status;
  logic [15:0] fin_value;
  logic        is_end;

  // Expected key byte and digit decode
  assign want    = 8'(key_chars >> {key_pos_r, 3'b000});
  assign hex     = hex_nibble(ch);
  assign cnt_inc = digit_cnt_r + 3'd1;
  assign is_end  = (ch == CH_NL) || (ch == CH_NUL);

  // Next state
  always_comb begin
    phase_nxt     = phase_r;
    key_pos_nxt   = key_pos_r;
    digit_cnt_nxt = digit_cnt_r;
    accum_nxt     = accum_r;
    fin           = 1'b0;
    fin_status    = ST_NAME;
    fin_value     = '0;
    unique case (phase_r)
      PH_KEY: begin
        if (key_pos_r < key_len) begin
          if (ch == CH_NUL || ch != want) begin
            fin = 1'b1;
          end else begin
            key_pos_nxt = key_pos_r + 4'd1;
          end
        end else if (ch != CH_EQ) begin
          fin = 1'b1;
        end else begin
          phase_nxt     = PH_DIGITS;
          digit_cnt_nxt = '0;
          accum_nxt     = '0;
        end
      end
      PH_DIGITS: begin
        if (is_end || (ch == CH_SP && digit_cnt_r == 3'd0)) begin
          fin        = 1'b1;
          fin_status = ST_VALUE;
        end else if (!hex[4]) begin
          fin = 1'b1;
        end else begin
          accum_nxt     = {accum_r[11:0], hex[3:0]};
          digit_cnt_nxt = cnt_inc;
          if (cnt_inc >= HEX_DIGITS) phase_nxt = PH_TERM;
        end
      end
      PH_TERM: begin
        fin = 1'b1;
        if (is_end || ch == CH_SP) begin
          fin_status = ST_OK;
          fin_value  = accum_r;
        end
      end
      default: begin
        // Skip to the record end
        if (ch == CH_NUL) begin
          phase_nxt     = PH_KEY;
          key_pos_nxt   = '0;
          digit_cnt_nxt = '0;
          accum_nxt     = '0;
        end
      end
    endcase
    // A decided record restarts on a zero byte, else skips to it
    if (fin) begin
      if (ch == CH_NUL) begin
        phase_nxt     = PH_KEY;
        key_pos_nxt   = '0;
        digit_cnt_nxt = '0;
        accum_nxt     = '0;
      end else begin
        phase_nxt = PH_SKIP;
      end
    end
  end

  // Result for this byte
  always_comb begin
    res.valid  = step && fin;
    res.status = fin_status;
    res.value  = fin_value;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_KEY;
      key_pos_r   <= '0;
      digit_cnt_r <= '0;
      accum_r     <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      key_pos_r   <= key_pos_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      accum_r     <= accum_nxt;
    end
  end

endmodule

// ----- sv/kh16_out_stage.sv -----
// Result register: holds one result item until the sink takes it.
`timescale 1ns / 1ps
module kh16_out_stage import kh16_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  kh16_result_t res,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [1:0]   out_status,
  output logic [15:0]  out_value,
  output logic         can_load
);

  logic        valid_r;
  logic [1:0]  status_r;
  logic [15:0] value_r;

  // Room for a new result when empty or being drained this cycle
  assign can_load = !valid_r || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res.valid) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (res.valid) begin
      status_r <= res.status;
      value_r  <= res.value;
    end
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_value  = value_r;

endmodule

// ----- sv/key_hex16_field_parser.sv -----
// Top level of the key/hex16 field parser.
// Takes one text byte per cycle: each record (ended by a zero byte) must
// read key, '=', four hex digits, then a newline, space or zero byte. One
// result item (status, value) leaves as soon as a record is decided; the
// rest of the record is skipped. Every byte is decided in the cycle it is
// accepted and its result lands in a single output register, so the block
// sustains one byte per cycle and out_ch.valid rises in the next cycle;
// in_ch.ready drops only while a result sits in that register and
// out_ch.ready is low. Registers: index 0 key characters (first in the low
// byte), index 1 key length (values above KEY_MAX_CHARS act as the max).
`timescale 1ns / 1ps
module key_hex16_field_parser import kh16_pkg::*; #(
  parameter int KEY_MAX_CHARS = KEY_MAX_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  kh16_in_if.sink    in_ch,
  kh16_out_if.source out_ch,
  kh16_cfg_if.sink   cfg_ch
);

  logic [KEY_MAX_CHARS*8-1:0] key_chars;
  logic [3:0]                 key_len;
  logic                       can_load;
  logic                       step;
  kh16_result_t               res;

  // Handshakes
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = can_load;
  assign step         = in_ch.valid && can_load;

  kh16_cfg_regs #(.KEY_MAX_CHARS(KEY_MAX_CHARS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_ch.valid),
    .wr_idx    (cfg_ch.index),
    .wr_data   (cfg_ch.data),
    .key_chars (key_chars),
    .key_len   (key_len)
  );

  kh16_parse_core #(.KEY_MAX_CHARS(KEY_MAX_CHARS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ch        (in_ch.ch),
    .key_chars (key_chars),
    .key_len   (key_len),
    .res       (res)
  );

  kh16_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_value  (out_ch.value),
    .can_load   (can_load)
  );

endmodule

// ----- sv/kh16_checker.sv -----
// Port-level checker of the key/hex16 field parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module kh16_checker import kh16_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_value,
  input logic        cfg_ready
);

  // A stalled result item stays offered
  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // Only defined status codes leave the block
  `AST_SAME(a_status_code, clk, rst_n, out_valid, out_status == ST_OK || out_status == ST_NAME || out_status == ST_VALUE, "bad status code")

  // Errors carry a zero value
  `AST_SAME(a_err_value, clk, rst_n, out_valid && out_status != ST_OK, out_value == 16'd0, "error with nonzero value")

  // Input is taken whenever the result register is free or draining
  `AST_SAME(a_in_ready, clk, rst_n, !out_valid || out_ready, in_ready && cfg_ready, "input stalled without cause")

endmodule

bind key_hex16_field_parser kh16_checker u_kh16_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_value  (out_ch.value),
  .cfg_ready  (cfg_ch.ready)
);
